// ----- sv/bmc_pkg.sv -----
// Package: shared types, codes and lookup functions of the button menu controller
`default_nettype none
package bmc_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_BUTTON = 2'd1;
    localparam logic [1:0] MODE_HOST   = 2'd2;
    localparam logic [1:0] MODE_CTRL   = 2'd3;

    // Event codes of a result
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ENTERED = 3'd1;
    localparam logic [2:0] EV_SAVED   = 3'd2;
    localparam logic [2:0] EV_LOCKED  = 3'd3;
    localparam logic [2:0] EV_HINT    = 3'd4;
    localparam logic [2:0] EV_ABORTED = 3'd5;
    localparam logic [2:0] EV_CAT_ADV = 3'd6;
    localparam logic [2:0] EV_VAL_ADV = 3'd7;

    // Categories
    localparam logic [1:0] SEL_TELEM  = 2'd0;
    localparam logic [1:0] SEL_STEADY = 2'd1;
    localparam logic [1:0] SEL_GAIN   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_LONG     = 1'b1;

    // Reset values
    localparam logic [9:0]  DEBOUNCE_RST   = 10'd30;
    localparam logic [13:0] LONG_RST       = 14'd2000;
    localparam logic [8:0]  PERIOD_RST     = 9'd100;
    localparam logic [1:0]  GAIN_RST       = 2'd1;

    // Divider length: one quotient bit per step over the timestamp
    localparam int DIV_STEPS = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEB,
        ST_LONG,
        ST_MISC,
        ST_PER,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic deb;
        logic lng;
        logic misc;
        logic per;
        logic div_step;
        logic div_last;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic active;
        logic out_busy;
    } status_t;

    function automatic logic [12:0] gain_coeff_of(input logic [1:0] g);
        logic [12:0] c;
        case (g)
            2'd0:    c = 13'd3200;
            2'd2:    c = 13'd7800;
            default: c = 13'd5046;
        endcase
        return c;
    endfunction

    function automatic logic [8:0] period_of(input logic [1:0] cat, input logic telem,
                                             input logic steady, input logic [1:0] g);
        logic [8:0] p;
        if (cat == SEL_TELEM) begin
            p = telem ? 9'd70 : 9'd500;
        end else if (cat == SEL_STEADY) begin
            p = steady ? 9'd90 : 9'd450;
        end else if (g == 2'd0) begin
            p = 9'd350;
        end else if (g == 2'd1) begin
            p = 9'd160;
        end else begin
            p = 9'd60;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- sv/button_menu_config_controller_core.sv -----
// Sequence: a tick item with the menu active passes debounce, long-hold check, period pick,
// 32 divider steps, result; with the menu inactive, no divider; other items: update, result.
// Throughput: one item at a time; the next is taken after the result registers, with the
// sequencer back in idle; a result still held by m_tready low holds the next one back.
// The 32 steps of the one-bit-per-cycle restoring divider set an active-menu tick's latency.
// Reset: aresetn is synchronous, active low; it clears the sequencer, the menu state,
// the configuration registers to their defaults, and the result valid flag.
`default_nettype none
module button_menu_config_controller_core
    import bmc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // left_raw[0], now_ms[32:1], flag[33]
    input  wire logic [1:0]             s_tuser,  // mode[1:0]
    // Results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // menu_active[0], category[2:1], telem_on[3], steady_on[4], gain_preset[6:5],
    // gain_coeff[19:7], led_period_ms[28:20], led_level[29], event_res[32:30]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [13:0]            cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    ctl_ready;

    assign cfg_ready = 1'b1;
    assign s_tready  = ctl_ready;

    // Sequencer
    bmc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (ctl_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // State, divider and result register
    bmc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ----- sv/bmc_controller.sv -----
// Controller: sequences one item through debounce, long hold, divider and result
`default_nettype none
module bmc_controller
    import bmc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Hold state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DEB;
                end
            end
            // Route a freshly loaded item by its kind
            ST_DEB:  state_next = status.is_tick ? ST_LONG : ST_MISC;
            ST_LONG: state_next = ST_PER;
            ST_MISC: state_next = ST_DONE;
            ST_PER: begin
                cnt_next   = '0;
                state_next = status.active ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DEB:  cmd.deb  = status.is_tick;
            ST_LONG: cmd.lng  = 1'b1;
            ST_MISC: cmd.misc = 1'b1;
            ST_PER:  cmd.per  = 1'b1;
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = cnt_last;
            end
            ST_DONE: cmd.emit = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/bmc_datapath.sv -----
// Datapath: menu state, debounce timing, sequential divider and result register
`default_nettype none
module bmc_datapath
    import bmc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_index,
    input  wire logic [13:0]            cfg_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire cmd_t                   cmd,
    output status_t                     status
);

    // Item latch
    logic [1:0]  mode_reg;
    logic        raw_reg, flag_reg;
    logic [31:0] now_reg;
    logic [2:0]  ev_reg, ev_next;

    // Configuration
    logic [9:0]  deb_ms_reg;
    logic [13:0] long_ms_reg;

    // Menu state
    logic        stable_reg, stable_next;
    logic [31:0] change_reg, change_next;
    logic [31:0] press_reg, press_next;
    logic        long_done_reg, long_done_next;
    logic        active_reg, active_next;
    logic [1:0]  cat_reg, cat_next;
    logic        telem_reg, telem_next;
    logic        steady_reg, steady_next;
    logic [1:0]  gain_reg, gain_next;
    logic        sv_telem_reg, sv_telem_next;
    logic        sv_steady_reg, sv_steady_next;
    logic [1:0]  sv_gain_reg, sv_gain_next;
    logic        host_reg, host_next;
    logic        ctrl_reg, ctrl_next;
    logic [8:0]  period_reg, period_next;
    logic        level_reg, level_next;

    // Divider
    logic [31:0] dvd_reg, dvd_next;
    logic [8:0]  rem_reg, rem_next;
    logic [9:0]  trial;
    logic        q_bit;

    // Result register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [31:0] since_change, since_press;
    logic        ready_now, host_new, ctrl_new, ready_new;
    logic [1:0]  cat_inc, gain_inc;

    assign since_change = now_reg - change_reg;
    assign since_press  = now_reg - press_reg;
    assign ready_now    = host_reg && ctrl_reg;
    assign host_new     = (mode_reg == MODE_HOST) ? flag_reg : host_reg;
    assign ctrl_new     = (mode_reg == MODE_CTRL) ? flag_reg : ctrl_reg;
    assign ready_new    = host_new && ctrl_new;
    assign cat_inc      = (cat_reg >= 2'd2) ? 2'd0 : cat_reg + 2'd1;
    assign gain_inc     = (gain_reg >= 2'd2) ? 2'd0 : gain_reg + 2'd1;
    assign trial        = {rem_reg, dvd_reg[31]};
    assign q_bit        = (trial >= {1'b0, period_reg});

    // Work out the next menu state for the current command
    always_comb begin
        ev_next        = ev_reg;
        stable_next    = stable_reg;
        change_next    = change_reg;
        press_next     = press_reg;
        long_done_next = long_done_reg;
        active_next    = active_reg;
        cat_next       = cat_reg;
        telem_next     = telem_reg;
        steady_next    = steady_reg;
        gain_next      = gain_reg;
        sv_telem_next  = sv_telem_reg;
        sv_steady_next = sv_steady_reg;
        sv_gain_next   = sv_gain_reg;
        host_next      = host_reg;
        ctrl_next      = ctrl_reg;
        period_next    = period_reg;
        level_next     = level_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;

        if (cmd.load) begin
            ev_next = EV_NONE;
        end

        // Debounce the raw level
        if (cmd.deb) begin
            if (raw_reg != stable_reg) begin
                if (change_reg == 32'd0) begin
                    change_next = now_reg;
                end else if (since_change >= {22'd0, deb_ms_reg}) begin
                    stable_next = raw_reg;
                    change_next = 32'd0;
                    if (!raw_reg) begin
                        press_next     = now_reg;
                        long_done_next = 1'b0;
                    end else begin
                        if (!long_done_reg && press_reg != 32'd0 &&
                            since_press < {18'd0, long_ms_reg} && active_reg) begin
                            cat_next = cat_inc;
                            ev_next  = EV_CAT_ADV;
                        end
                        press_next = 32'd0;
                    end
                end
            end else begin
                change_next = 32'd0;
            end
        end

        // Detect a long hold
        if (cmd.lng) begin
            if (!stable_reg && !long_done_reg && press_reg != 32'd0 &&
                since_press >= {18'd0, long_ms_reg}) begin
                long_done_next = 1'b1;
                if (active_reg) begin
                    sv_telem_next  = telem_reg;
                    sv_steady_next = steady_reg;
                    sv_gain_next   = gain_reg;
                    active_next    = 1'b0;
                    ev_next        = EV_SAVED;
                end else if (!ready_now) begin
                    ev_next = EV_LOCKED;
                end else begin
                    active_next = 1'b1;
                    cat_next    = SEL_TELEM;
                    ev_next     = EV_ENTERED;
                end
            end
        end

        // Second button and readiness updates
        if (cmd.misc) begin
            if (mode_reg == MODE_BUTTON) begin
                if (flag_reg) begin
                    if (active_reg) begin
                        case (cat_reg)
                            SEL_TELEM:  telem_next  = !telem_reg;
                            SEL_STEADY: steady_next = !steady_reg;
                            default:    gain_next   = gain_inc;
                        endcase
                        ev_next = EV_VAL_ADV;
                    end else if (ready_now) begin
                        ev_next = EV_HINT;
                    end
                end
            end else begin
                host_next = host_new;
                ctrl_next = ctrl_new;
                if (!ready_new && active_reg) begin
                    active_next = 1'b0;
                    telem_next  = sv_telem_reg;
                    steady_next = sv_steady_reg;
                    gain_next   = sv_gain_reg;
                    ev_next     = EV_ABORTED;
                end
            end
        end

        // Pick the blink period and prime the divider
        if (cmd.per && active_reg) begin
            period_next = period_of(cat_reg, telem_reg, steady_reg, gain_reg);
            dvd_next    = now_reg;
            rem_next    = '0;
        end

        // One restoring step; the final quotient bit is the LED level
        if (cmd.div_step) begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            rem_next = q_bit ? 9'(trial - {1'b0, period_reg}) : trial[8:0];
            if (cmd.div_last) begin
                level_next = q_bit;
            end
        end
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_ms_reg    <= DEBOUNCE_RST;
            long_ms_reg   <= LONG_RST;
            stable_reg    <= 1'b1;
            change_reg    <= '0;
            press_reg     <= '0;
            long_done_reg <= 1'b0;
            active_reg    <= 1'b0;
            cat_reg       <= SEL_TELEM;
            telem_reg     <= 1'b0;
            steady_reg    <= 1'b0;
            gain_reg      <= GAIN_RST;
            sv_telem_reg  <= 1'b0;
            sv_steady_reg <= 1'b0;
            sv_gain_reg   <= GAIN_RST;
            host_reg      <= 1'b0;
            ctrl_reg      <= 1'b0;
            period_reg    <= PERIOD_RST;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_DEBOUNCE) begin
                    deb_ms_reg <= cfg_data[9:0];
                end else begin
                    long_ms_reg <= cfg_data;
                end
            end
            stable_reg    <= stable_next;
            change_reg    <= change_next;
            press_reg     <= press_next;
            long_done_reg <= long_done_next;
            active_reg    <= active_next;
            cat_reg       <= cat_next;
            telem_reg     <= telem_next;
            steady_reg    <= steady_next;
            gain_reg      <= gain_next;
            sv_telem_reg  <= sv_telem_next;
            sv_steady_reg <= sv_steady_next;
            sv_gain_reg   <= sv_gain_next;
            host_reg      <= host_next;
            ctrl_reg      <= ctrl_next;
            period_reg    <= period_next;
            level_reg     <= level_next;
            // Drop a taken result, raise a new one
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ev_reg  <= ev_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (cmd.load) begin
            mode_reg <= s_tuser;
            raw_reg  <= s_tdata[0];
            now_reg  <= s_tdata[32:1];
            flag_reg <= s_tdata[33];
        end
        if (cmd.emit) begin
            out_data_reg <= {7'd0, ev_reg, level_reg, period_reg, gain_coeff_of(gain_reg),
                             gain_reg, steady_reg, telem_reg, cat_reg, active_reg};
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.is_tick  = (mode_reg == MODE_TICK);
    assign status.active   = active_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule
`default_nettype wire

// ----- tb/tb_button_menu_config_controller_core.sv -----
// Testbench for the button menu controller core: scoreboard-checked directed and random traffic
`timescale 1ns / 100ps

import bmc_pkg::*;

// One expected result, field by field
typedef struct {
    logic        active;
    logic [1:0]  cat;
    logic        telem;
    logic        steady;
    logic [1:0]  gain;
    logic [12:0] coeff;
    logic [8:0]  period;
    logic        level;
    logic [2:0]  ev;
} menu_res_t;

// Menu state predictor and store of expected results
class menu_scoreboard;
    logic [9:0]  deb_ms;
    logic [13:0] long_ms;
    logic        stable, long_done, active, telem, steady;
    logic        sv_telem, sv_steady, host_ok, ctrl_ok, level;
    logic [31:0] chg_t, press_t;
    logic [1:0]  cat, gain, sv_gain;
    logic [8:0]  period;
    menu_res_t   pending[$];
    int          errors;
    int          results;
    int          ev_count[8];

    function new();
        deb_ms = DEBOUNCE_RST;
        long_ms = LONG_RST;
        stable = 1'b1;
        chg_t = '0;
        press_t = '0;
        long_done = 1'b0;
        active = 1'b0;
        cat = SEL_TELEM;
        telem = 1'b0;
        steady = 1'b0;
        gain = GAIN_RST;
        sv_telem = 1'b0;
        sv_steady = 1'b0;
        sv_gain = GAIN_RST;
        host_ok = 1'b0;
        ctrl_ok = 1'b0;
        period = PERIOD_RST;
        level = 1'b0;
        errors = 0;
        results = 0;
        foreach (ev_count[i]) ev_count[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [13:0] val);
        if (idx == CFG_DEBOUNCE) begin
            deb_ms = val[9:0];
        end else begin
            long_ms = val;
        end
    endfunction

    function int outstanding();
        return pending.size();
    endfunction

    // Long hold: save and leave, enter, or refuse when the link is down
    function logic [2:0] long_hold();
        if (active) begin
            sv_telem = telem;
            sv_steady = steady;
            sv_gain = gain;
            active = 1'b0;
            return EV_SAVED;
        end
        if (!(host_ok && ctrl_ok)) return EV_LOCKED;
        active = 1'b1;
        cat = SEL_TELEM;
        return EV_ENTERED;
    endfunction

    // Readiness loss while in the menu reverts to the saved copies
    function logic [2:0] drop_check();
        if (!(host_ok && ctrl_ok) && active) begin
            active = 1'b0;
            telem = sv_telem;
            steady = sv_steady;
            gain = sv_gain;
            return EV_ABORTED;
        end
        return EV_NONE;
    endfunction

    function logic [2:0] button_tick(logic raw, logic [31:0] now);
        logic [2:0]  ev;
        logic [31:0] quot;
        ev = EV_NONE;
        // Debounce the first button level
        if (raw != stable) begin
            if (chg_t == 0) begin
                chg_t = now;
            end else if (now - chg_t >= deb_ms) begin
                stable = raw;
                chg_t = '0;
                if (!stable) begin
                    press_t = now;
                    long_done = 1'b0;
                end else begin
                    if (!long_done && press_t != 0 && now - press_t < long_ms && active) begin
                        cat = (cat == SEL_GAIN) ? SEL_TELEM : cat + 2'd1;
                        ev = EV_CAT_ADV;
                    end
                    press_t = '0;
                end
            end
        end else begin
            chg_t = '0;
        end
        // Fire the long hold once per press
        if (!stable && !long_done && press_t != 0 && now - press_t >= long_ms) begin
            long_done = 1'b1;
            ev = long_hold();
        end
        // Refresh the LED while the menu is up
        if (active) begin
            if (cat == SEL_TELEM) begin
                period = telem ? 9'd70 : 9'd500;
            end else if (cat == SEL_STEADY) begin
                period = steady ? 9'd90 : 9'd450;
            end else if (gain == 2'd0) begin
                period = 9'd350;
            end else if (gain == 2'd1) begin
                period = 9'd160;
            end else begin
                period = 9'd60;
            end
            quot = now / {23'd0, period};
            level = quot[0];
        end
        return ev;
    endfunction

    // Predict the result of one accepted transaction
    function void note_input(logic [1:0] mode, logic raw, logic [31:0] now, logic fl);
        menu_res_t  r;
        logic [2:0] ev;
        ev = EV_NONE;
        case (mode)
            MODE_TICK: ev = button_tick(raw, now);
            MODE_BUTTON: begin
                if (fl && active) begin
                    case (cat)
                        SEL_TELEM:  telem = ~telem;
                        SEL_STEADY: steady = ~steady;
                        default:    gain = (gain == 2'd2) ? 2'd0 : gain + 2'd1;
                    endcase
                    ev = EV_VAL_ADV;
                end else if (fl && host_ok && ctrl_ok) begin
                    ev = EV_HINT;
                end
            end
            MODE_HOST: begin
                host_ok = fl;
                ev = drop_check();
            end
            default: begin
                ctrl_ok = fl;
                ev = drop_check();
            end
        endcase
        r.active = active;
        r.cat = cat;
        r.telem = telem;
        r.steady = steady;
        r.gain = gain;
        r.coeff = (gain == 2'd0) ? 13'd3200 : (gain == 2'd2) ? 13'd7800 : 13'd5046;
        r.period = period;
        r.level = level;
        r.ev = ev;
        pending.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        end
    endfunction

    // Check one result transaction against the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] d);
        menu_res_t e;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, d);
            return;
        end
        e = pending.pop_front();
        results++;
        ev_count[e.ev]++;
        compare("menu_active", e.active, d[0]);
        compare("category", e.cat, d[2:1]);
        compare("telem_on", e.telem, d[3]);
        compare("steady_on", e.steady, d[4]);
        compare("gain_preset", e.gain, d[6:5]);
        compare("gain_coeff", e.coeff, d[19:7]);
        compare("led_period_ms", e.period, d[28:20]);
        compare("led_level", e.level, d[29]);
        compare("event_res", e.ev, d[32:30]);
    endfunction
endclass

module tb_button_menu_config_controller_core;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // left_raw[0], now_ms[32:1], flag[33]
    logic [1:0]             s_tuser;   // mode[1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // menu_active[0] .. event_res[32:30]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [13:0]            cfg_data;

    menu_scoreboard sb;
    logic [31:0]    clk_ms;
    bit             tx_idle;
    bit             rx_idle;
    int             n_items;
    int             n_settings;

    button_menu_config_controller_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up on a hung run
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: accept with random back-pressure
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_result(m_tdata);
            stall = rx_idle ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Send one input transaction after a random gap
    task automatic put_item(input logic [1:0] mode, input logic raw, input logic [31:0] now,
                            input logic fl);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {6'd0, fl, now, raw};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_input(mode, raw, now, fl);
        n_items++;
    endtask

    // Advance the millisecond clock and send a tick
    task automatic tick_step(input logic raw, input logic [31:0] adv);
        clk_ms = clk_ms + adv;
        put_item(MODE_TICK, raw, clk_ms, 1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every expected result is in
    task automatic hold_until_empty();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [13:0] deb, input logic [13:0] lng);
        hold_until_empty();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Press, hold for a while, release; optionally bounce first
    task automatic press_gesture(input bit is_long);
        logic [31:0] hold;
        int          k;
        hold = is_long ? sb.long_ms + $urandom_range(0, sb.long_ms)
                       : $urandom_range(0, sb.long_ms / 2);
        if ($urandom_range(0, 4) == 0) begin
            tick_step(1'b0, $urandom_range(1, 5));
            tick_step(1'b1, $urandom_range(1, 5));
        end
        tick_step(1'b0, $urandom_range(1, 20));
        tick_step(1'b0, sb.deb_ms + $urandom_range(0, 10));
        k = $urandom_range(0, 3);
        repeat (k + 1) tick_step(1'b0, hold / (k + 1));
        tick_step(1'b1, $urandom_range(1, 20));
        tick_step(1'b1, sb.deb_ms + $urandom_range(0, 10));
    endtask

    // Directed opening at the reset settings
    task automatic opening_checks();
        put_item(MODE_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1);
        put_item(MODE_TICK, 1'b1, 32'd0, 1'b0);
        // second button while inactive and not ready
        put_item(MODE_BUTTON, 1'b0, 32'd0, 1'b1);
        put_item(MODE_HOST, 1'b1, 32'd0, 1'b1);
        // readiness update while inactive only stores the flag
        put_item(MODE_CTRL, 1'b0, 32'hFFFF_FFFF, 1'b1);
        put_item(MODE_BUTTON, 1'b1, 32'h5555_5555, 1'b1);
        put_item(MODE_BUTTON, 1'b0, 32'hAAAA_AAAA, 1'b0);
        // press stabilising at a zero timestamp never counts
        put_item(MODE_TICK, 1'b0, 32'hFFFF_FF00, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd0, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd5000, 1'b1);
        put_item(MODE_TICK, 1'b1, 32'd5010, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd5050, 1'b0);
        // long hold with the link down
        put_item(MODE_CTRL, 1'b0, 32'd0, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd6000, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd6030, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd8030, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd8040, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd8070, 1'b0);
        put_item(MODE_CTRL, 1'b0, 32'd0, 1'b1);
        // enter the menu, then step category and value
        put_item(MODE_TICK, 1'b0, 32'd9000, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd9030, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd11030, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd11040, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd11070, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd12000, 1'b0);
        put_item(MODE_TICK, 1'b0, 32'd12030, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd12100, 1'b0);
        put_item(MODE_TICK, 1'b1, 32'd12130, 1'b0);
        put_item(MODE_BUTTON, 1'b0, 32'd0, 1'b1);
        // host drop aborts and reverts
        put_item(MODE_HOST, 1'b0, 32'd0, 1'b0);
        clk_ms = 32'd20000;
    endtask

    // Mostly well-formed gestures with some noise and readiness churn
    task automatic menu_traffic(input int count);
        int stop;
        int pick;
        stop = n_items + count;
        while (n_items < stop) begin
            if ($urandom_range(0, 63) == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 199) == 0) hold_until_empty();
            if ($urandom_range(0, 39) == 0) clk_ms = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                put_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom(),
                         1'($urandom_range(0, 1)));
            end else if (pick < 16) begin
                put_item((pick < 12) ? MODE_HOST : MODE_CTRL, 1'($urandom_range(0, 1)),
                         $urandom(), 1'($urandom_range(0, 3) != 0));
            end else if (pick < 40) begin
                put_item(MODE_BUTTON, 1'($urandom_range(0, 1)), $urandom(),
                         1'($urandom_range(0, 4) != 0));
            end else begin
                press_gesture(pick >= 75);
            end
        end
    endtask

    // Main sequence
    initial begin
        sb = new();
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= '0;
        aresetn <= 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        clk_ms = 32'd1000;
        n_items = 0;
        n_settings = 1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        opening_checks();
        menu_traffic(420);
        set_config(14'd1, 14'd100);
        menu_traffic(420);
        set_config(14'd1000, 14'd10000);
        menu_traffic(420);
        // zero delays: comparisons apply as written
        set_config(14'd0, 14'd0);
        menu_traffic(200);
        set_config(14'($urandom_range(1, 1000)), 14'($urandom_range(100, 10000)));
        menu_traffic(340);

        // Drain and let the pipeline settle
        hold_until_empty();
        repeat (50) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d results missing, expected %0d, actual 0", $time,
                     sb.outstanding(), sb.outstanding());
            sb.errors += sb.outstanding();
        end

        $display("Run covered %0d transactions and %0d results over %0d register settings.",
                 n_items, sb.results, n_settings);
        $display("Events: entered %0d, saved %0d, locked %0d, hint %0d,",
                 sb.ev_count[EV_ENTERED], sb.ev_count[EV_SAVED], sb.ev_count[EV_LOCKED],
                 sb.ev_count[EV_HINT]);
        $display("        aborted %0d, category %0d, value %0d",
                 sb.ev_count[EV_ABORTED], sb.ev_count[EV_CAT_ADV], sb.ev_count[EV_VAL_ADV]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
